// File: design/text_mode_console_unit_assert.svh
// Assertion macros for the text console unit, clocked on clk and reset by arst_n.
`ifndef TEXT_MODE_CONSOLE_UNIT_ASSERT_SVH
`define TEXT_MODE_CONSOLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TCON_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// Next-cycle implication.
`define TCON_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define TCON_ASSERT_IMPL(label, ante, cons)
`define TCON_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/tcon_pkg.sv
// Shared types and constants of the text console unit.
package tcon_pkg;

	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int RADDR_W   = 11;
	localparam int POS_OUT_W = 11;
	localparam int CELL_W    = 16;
	localparam int DATA_W    = 32;
	localparam int USER_W    = 2;

	// Blank cell: white on black space
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

	typedef enum logic [USER_W-1:0] {
		MODE_PUT   = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	// Input word payload, first field in the highest bits
	typedef struct packed {
		logic [RADDR_W-1:0] read_address;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic [CHAR_W-1:0]  char_code;
	} in_item_t;

	// Output word payload, first field in the highest bits
	typedef struct packed {
		logic [CELL_W-1:0]    cell_word;
		logic [POS_OUT_W-1:0] cursor_position;
	} out_item_t;

	localparam int IN_ITEM_W  = $bits(in_item_t);
	localparam int OUT_ITEM_W = $bits(out_item_t);

endpackage

// File: design/tcon_fbuf.sv
// Frame buffer memory: one write port, one read port with registered read data.
module tcon_fbuf #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [ADDR_W-1:0]              waddr,
	input  logic [tcon_pkg::CELL_W-1:0]    wdata,
	input  logic [ADDR_W-1:0]              raddr,
	output logic [tcon_pkg::CELL_W-1:0]    rdata
);

	logic [tcon_pkg::CELL_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: design/tcon_ctrl.sv
// Console sequencer: cursor, put/clear/read handling, scroll and blank sweeps.
module tcon_ctrl #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8,
	parameter int ADDR_W   = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  tcon_pkg::mode_t             in_mode,
	input  tcon_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tcon_pkg::out_item_t         out_item,
	output logic                        mem_we,
	output logic [ADDR_W-1:0]           mem_waddr,
	output logic [tcon_pkg::CELL_W-1:0] mem_wdata,
	output logic [ADDR_W-1:0]           mem_raddr,
	input  logic [tcon_pkg::CELL_W-1:0] mem_rdata
);

	localparam int CELLS      = COLUMNS * ROWS;
	localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int NC_W       = $clog2(COLUMNS + TAB_STOP);
	localparam int NR_W       = $clog2(ROWS + 1);
	localparam int TAB_W      = $clog2(TAB_STOP);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] MOVE_END  = ADDR_W'(MOVE_CELLS);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_BLANK,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [ADDR_W-1:0]             sweep_q;
	logic [COL_W-1:0]              col_q;
	logic [ROW_W-1:0]              row_q;
	logic [TAB_W-1:0]              rem_q;
	logic                          rd_ok_q;
	logic [tcon_pkg::CELL_W-1:0]   cell_q;
	logic                          wr_pend_s1;
	logic [ADDR_W-1:0]             wr_addr_s1;
	logic                          out_valid_q;
	tcon_pkg::out_item_t           out_item_q;

	logic [ADDR_W-1:0]             cur_lin;
	logic [NC_W-1:0]               nc;
	logic [NR_W-1:0]               nr;
	logic [TAB_W-1:0]              nrem;
	logic                          printable;
	logic                          scroll;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Linear cursor index
	assign cur_lin = ADDR_W'(ADDR_W'(row_q * COLUMNS) + ADDR_W'(col_q));

	assign printable = in_item.char_code inside {[tcon_pkg::CH_SPACE:tcon_pkg::CH_DEL]};

	// Next cursor for a put
	always_comb begin
		nc   = NC_W'(col_q);
		nr   = NR_W'(row_q);
		nrem = rem_q;
		case (in_item.char_code)
			tcon_pkg::CH_BS: begin
				if (col_q != '0) begin
					nc   = NC_W'(col_q) - NC_W'(1);
					nrem = (rem_q == '0) ? TAB_W'(TAB_STOP - 1) : rem_q - TAB_W'(1);
				end
			end
			tcon_pkg::CH_TAB: begin
				nc   = NC_W'(col_q) + NC_W'(TAB_STOP) - NC_W'(rem_q);
				nrem = '0;
			end
			tcon_pkg::CH_CR: begin
				nc   = '0;
				nrem = '0;
			end
			tcon_pkg::CH_LF: begin
				nc   = '0;
				nr   = NR_W'(row_q) + NR_W'(1);
				nrem = '0;
			end
			default: begin
				if (printable) begin
					nc   = NC_W'(col_q) + NC_W'(1);
					nrem = (rem_q == TAB_W'(TAB_STOP - 1)) ? '0 : rem_q + TAB_W'(1);
				end
			end
		endcase
		// Wrap at the right edge
		if (nc >= NC_W'(COLUMNS)) begin
			nc   = '0;
			nr   = nr + NR_W'(1);
			nrem = '0;
		end
		scroll = (nr == NR_W'(ROWS));
	end

	// Memory port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = tcon_pkg::BLANK_CELL;
		mem_raddr = ADDR_W'(in_item.read_address);
		case (state_q)
			ST_IDLE: begin
				mem_we    = in_valid && (in_mode == tcon_pkg::MODE_PUT) && printable;
				mem_waddr = cur_lin;
				mem_wdata = {in_item.bg_color, in_item.fg_color, in_item.char_code};
			end
			ST_SCROLL: begin
				mem_we    = wr_pend_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = mem_rdata;
				mem_raddr = ADDR_W'(sweep_q + ADDR_W'(COLUMNS));
			end
			ST_INIT, ST_BLANK: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequencer state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			rem_q       <= '0;
			rd_ok_q     <= 1'b0;
			cell_q      <= '0;
			wr_pend_s1  <= 1'b0;
			wr_addr_s1  <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			// Drop the output word once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sweep_q == LAST_CELL) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cell_q <= '0;
						case (in_mode)
							tcon_pkg::MODE_PUT: begin
								col_q <= COL_W'(nc);
								row_q <= scroll ? ROW_W'(ROWS - 1) : ROW_W'(nr);
								rem_q <= nrem;
								if (scroll) begin
									sweep_q <= '0;
									state_q <= ST_SCROLL;
								end else begin
									state_q <= ST_DONE;
								end
							end
							tcon_pkg::MODE_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								rem_q   <= '0;
								sweep_q <= '0;
								state_q <= ST_BLANK;
							end
							tcon_pkg::MODE_READ: begin
								rd_ok_q <= (int'(in_item.read_address) < CELLS);
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					cell_q  <= rd_ok_q ? mem_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					// Read one row down, write it back in the next cycle
					if (sweep_q == MOVE_END) begin
						wr_pend_s1 <= 1'b0;
						state_q    <= ST_BLANK;
					end else begin
						wr_pend_s1 <= 1'b1;
						wr_addr_s1 <= sweep_q;
						sweep_q    <= sweep_q + ADDR_W'(1);
					end
				end
				ST_BLANK: begin
					if (sweep_q == LAST_CELL) begin
						state_q <= ST_DONE;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_DONE: begin
					// Hand over when the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q                <= 1'b1;
						out_item_q.cursor_position <= tcon_pkg::POS_OUT_W'(cur_lin);
						out_item_q.cell_word       <= cell_q;
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/text_mode_console_unit.sv
// Text console unit top level: a COLUMNS x ROWS cell buffer with a cursor, fed
// by a word stream of put, clear and read commands, one result word per command.
// After reset the unit blanks the buffer, one cell per cycle, and takes no word
// until the sweep is done. A put or an unknown command goes through the done
// state to the registered result word; a read first waits in the read state for
// the registered buffer read. A clear walks the buffer once. A put that moves the
// cursor below the last row scrolls: a copy pass moves each row up by one, then
// the bottom row is blanked. Commands are handled one at a time; a new word is
// taken while the last result waits.
`include "text_mode_console_unit_assert.svh"
module text_mode_console_unit #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// char_code[7:0], bg_color[11:8], fg_color[15:12], read_address[26:16]
	input  logic [tcon_pkg::DATA_W-1:0]   s_tdata,
	// mode[1:0]
	input  logic [tcon_pkg::USER_W-1:0]   s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cursor_position[10:0], cell_word[26:11]
	output logic [tcon_pkg::DATA_W-1:0]   m_tdata
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);

	tcon_pkg::in_item_t          in_item;
	tcon_pkg::out_item_t         out_item;
	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr;
	logic [tcon_pkg::CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]           mem_raddr;
	logic [tcon_pkg::CELL_W-1:0] mem_rdata;

	// Unpack and pack the stream words
	assign in_item = tcon_pkg::in_item_t'(s_tdata[tcon_pkg::IN_ITEM_W-1:0]);
	assign m_tdata = tcon_pkg::DATA_W'(out_item);

	tcon_ctrl #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP),
		.ADDR_W   (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (tcon_pkg::mode_t'(s_tuser)),
		.in_item   (in_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tcon_fbuf #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_fbuf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// One command in flight: ready drops right after a word is taken
	`TCON_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// Reported cursor stays inside the buffer, checked when CELLS is at most 2048
	`TCON_ASSERT_IMPL(a_cursor_range, m_tvalid, (CELLS > 2048) || (int'(out_item.cursor_position) < CELLS))
	// No buffer write once the unit is waiting for a command
	`TCON_ASSERT_IMPL(a_idle_write, s_tready && !s_tvalid, !mem_we)

endmodule
